[hdl/pde_pkg.sv]
`timescale 1ns / 1ps

package pde_pkg;

  localparam int PIN_LENGTH = 6;
  localparam int CNT_W      = $clog2(PIN_LENGTH + 1);

  localparam logic [1:0] SYM_NONE  = 2'd0;
  localparam logic [1:0] SYM_SHORT = 2'd1;
  localparam logic [1:0] SYM_LONG  = 2'd2;

  typedef logic [PIN_LENGTH-1:0][1:0] pin_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_GET   = 2'd2,
    MODE_SET   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_NONE          = 4'd0,
    ST_OK            = 4'd1,
    ST_CONFIRM       = 4'd2,
    ST_VERIFY_FAILED = 4'd3,
    ST_TIMEOUT       = 4'd4,
    ST_KEEPALIVE     = 4'd5,
    ST_NOT_SATISFIED = 4'd6,
    ST_BAD_INS       = 4'd7,
    ST_BAD_CLASS     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    REG_CLASS     = 3'd0,
    REG_CHECK     = 3'd1,
    REG_GET       = 3'd2,
    REG_SET       = 3'd3,
    REG_DOT       = 3'd4,
    REG_TIMEOUT   = 3'd5,
    REG_KEEPALIVE = 3'd6,
    REG_SAMPLE    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  class_code;
    logic [7:0]  check_code;
    logic [7:0]  get_code;
    logic [7:0]  set_code;
    logic [15:0] dot_ms;
    logic [15:0] timeout_ms;
    logic [15:0] keepalive_ms;
    logic [15:0] sample_ms;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  req_class;
    logic [7:0]  req_ins;
    logic        button_level;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [3:0] status_code;
    logic       reply_sent;
    logic       pin_confirmed;
    logic       led_on;
    logic       session_busy;
  } rsp_t;

endpackage

[hdl/pde_cfg.sv]
`timescale 1ns / 1ps

module pde_cfg
  import pde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  addr,
  input  logic [15:0] wdata,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_code   <= 8'd0;
      cfg.check_code   <= 8'd1;
      cfg.get_code     <= 8'd2;
      cfg.set_code     <= 8'd3;
      cfg.dot_ms       <= 16'd500;
      cfg.timeout_ms   <= 16'd5000;
      cfg.keepalive_ms <= 16'd400;
      cfg.sample_ms    <= 16'd50;
    end else if (wr_en) begin
      case (cfg_reg_t'(addr))
        REG_CLASS:     cfg.class_code   <= wdata[7:0];
        REG_CHECK:     cfg.check_code   <= wdata[7:0];
        REG_GET:       cfg.get_code     <= wdata[7:0];
        REG_SET:       cfg.set_code     <= wdata[7:0];
        REG_DOT:       cfg.dot_ms       <= wdata;
        REG_TIMEOUT:   cfg.timeout_ms   <= wdata;
        REG_KEEPALIVE: cfg.keepalive_ms <= wdata;
        REG_SAMPLE:    cfg.sample_ms    <= wdata;
        default: ;
      endcase
    end
  end

endmodule

[hdl/pde_engine.sv]
`timescale 1ns / 1ps

module pde_engine
  import pde_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t rsp
);

  mode_t             mode, mode_next;
  logic              last_level, last_level_next;
  logic [31:0]       press_start, press_start_next;
  logic [CNT_W-1:0]  count, count_next;
  pin_t              entered, entered_next;
  pin_t              stored_pin, stored_pin_next;
  logic              confirmed, confirmed_next;
  logic [31:0]       last_keepalive, last_keepalive_next;
  logic [31:0]       last_sample, last_sample_next;

  logic [31:0] dt_press, dt_keep, dt_sample;
  logic        no_pin;
  logic        timed_out, keep_due, sample_due;

  assign dt_press   = req.now_ms - press_start;
  assign dt_keep    = req.now_ms - last_keepalive;
  assign dt_sample  = req.now_ms - last_sample;
  assign no_pin     = (stored_pin[0] == SYM_NONE);
  assign timed_out  = dt_press  > {16'd0, cfg.timeout_ms};
  assign keep_due   = dt_keep   > {16'd0, cfg.keepalive_ms};
  assign sample_due = dt_sample > {16'd0, cfg.sample_ms};

  always_comb begin
    logic [3:0] status;
    logic       reply;
    logic       done;
    logic       match;
    logic [1:0] sym;

    mode_next           = mode;
    last_level_next     = last_level;
    press_start_next    = press_start;
    count_next          = count;
    entered_next        = entered;
    stored_pin_next     = stored_pin;
    confirmed_next      = confirmed;
    last_keepalive_next = last_keepalive;
    last_sample_next    = last_sample;
    status              = ST_NONE;
    reply               = 1'b0;
    done                = 1'b0;
    match               = 1'b0;
    sym                 = (dt_press < {16'd0, cfg.dot_ms}) ? SYM_SHORT : SYM_LONG;

    if (!req.req_type) begin
      // any request drops the running session first
      mode_next        = MODE_IDLE;
      last_level_next  = 1'b0;
      press_start_next = '0;
      count_next       = '0;
      entered_next     = '0;
      if (req.req_class != cfg.class_code) begin
        status = ST_BAD_CLASS;
        reply  = 1'b1;
      end else if (req.req_ins == cfg.check_code) begin
        mode_next = MODE_CHECK;
      end else if (req.req_ins == cfg.get_code) begin
        if (no_pin) begin
          status = ST_NOT_SATISFIED;
          reply  = 1'b1;
        end else begin
          mode_next = MODE_GET;
        end
      end else if (req.req_ins == cfg.set_code) begin
        if (!no_pin && !confirmed) begin
          status = ST_VERIFY_FAILED;
          reply  = 1'b1;
        end else begin
          mode_next = MODE_SET;
        end
      end else begin
        status = ST_BAD_INS;
        reply  = 1'b1;
      end
      if (mode_next != MODE_IDLE) begin
        confirmed_next      = 1'b0;
        press_start_next    = req.now_ms;
        last_keepalive_next = req.now_ms;
        last_sample_next    = req.now_ms;
      end
    end else if (mode != MODE_IDLE) begin
      if (timed_out) begin
        // a check session times out silently: reply with no status
        if (mode != MODE_CHECK) status = ST_TIMEOUT;
        reply = 1'b1;
        done  = 1'b1;
      end else if (mode != MODE_CHECK && keep_due) begin
        status              = ST_KEEPALIVE;
        reply               = 1'b1;
        last_keepalive_next = req.now_ms;
      end else if (sample_due) begin
        last_sample_next = req.now_ms;
        if (req.button_level != last_level) begin
          last_level_next = req.button_level;
          if (req.button_level) begin
            press_start_next = req.now_ms;
          end else begin
            if (count < CNT_W'(PIN_LENGTH)) begin
              for (int i = 0; i < PIN_LENGTH; i++) begin
                if (count == CNT_W'(i)) entered_next[i] = sym;
              end
              count_next = count + 1'b1;
            end
            if (count_next >= CNT_W'(PIN_LENGTH) || (mode == MODE_CHECK && no_pin)) begin
              reply = 1'b1;
              done  = 1'b1;
              match = (entered_next == stored_pin);
              case (mode)
                MODE_CHECK: begin
                  if (no_pin || match) confirmed_next = 1'b1;
                end
                MODE_GET: begin
                  confirmed_next = match;
                  status         = match ? ST_CONFIRM : ST_VERIFY_FAILED;
                end
                MODE_SET: begin
                  stored_pin_next = entered_next;
                  status          = ST_OK;
                end
                default: ;
              endcase
            end
          end
        end
      end
      if (done) begin
        mode_next        = MODE_IDLE;
        last_level_next  = 1'b0;
        press_start_next = '0;
        count_next       = '0;
        entered_next     = '0;
      end
    end

    rsp.status_code   = status;
    rsp.reply_sent    = reply;
    rsp.pin_confirmed = confirmed_next;
    rsp.session_busy  = (mode_next != MODE_IDLE);
    rsp.led_on        = (mode_next != MODE_IDLE) && last_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      last_level     <= 1'b0;
      press_start    <= '0;
      count          <= '0;
      entered        <= '0;
      stored_pin     <= '0;
      confirmed      <= 1'b0;
      last_keepalive <= '0;
      last_sample    <= '0;
    end else if (take) begin
      mode           <= mode_next;
      last_level     <= last_level_next;
      press_start    <= press_start_next;
      count          <= count_next;
      entered        <= entered_next;
      stored_pin     <= stored_pin_next;
      confirmed      <= confirmed_next;
      last_keepalive <= last_keepalive_next;
      last_sample    <= last_sample_next;
    end
  end

endmodule

[hdl/press_duration_pin_entry.sv]
`timescale 1ns / 1ps

// channel  | signals                                 | word
// ---------+-----------------------------------------+-------------------------
// req      | req_valid, req_stall, req_word          | request or button sample
// rsp      | rsp_valid, rsp_stall, rsp_word          | status and session flags
// cfg      | cfg_valid, cfg_ready, cfg_addr, cfg_wdata | register write
//
// One word per clock in steady state while rsp is not stalled; a taken word sits
// in the input register and the combinational session update loads its result
// into the result register, from which rsp offers it. rst is
// synchronous and clears all state, the stored PIN included. A stall on rsp
// holds the result register; req_stall follows it in the same cycle while the
// input register is full, and an empty input register still takes one word.
// cfg_ready is always high.

module press_duration_pin_entry
  import pde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg;
  req_t hold;
  logic hold_valid;
  rsp_t result;
  logic res_free;
  logic advance;

  assign cfg_ready = 1'b1;
  assign res_free  = !rsp_valid || !rsp_stall;
  assign advance   = hold_valid && res_free;
  assign req_stall = hold_valid && !res_free;

  pde_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_valid && cfg_ready),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  pde_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .req  (hold),
    .cfg  (cfg),
    .rsp  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_free) begin
      rsp_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_word <= result;
    end
  end

`ifndef ASSERT_OFF
  a_advance_gives_word: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("taken word produced no result");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid)
    else $error("waiting input word dropped");

  a_led_needs_session: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.led_on |-> rsp_word.session_busy)
    else $error("led on outside a session");

  a_status_has_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status_code != ST_NONE |-> rsp_word.reply_sent)
    else $error("status without a reply");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pde_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  // Tracks the PIN session engine word by word and checks its results in order.
  class pin_session_tracker;
    cfg_t        regs;
    mode_t       mode;
    logic        level;
    logic [31:0] press_at;
    logic [31:0] keepalive_at;
    logic [31:0] sample_at;
    int          symbols;
    pin_t        entered;
    pin_t        stored;
    logic        confirmed;
    rsp_t        due[$];
    int          errors;
    int          checked;
    logic [8:0]  status_seen;

    function new();
      regs.class_code   = 8'd0;
      regs.check_code   = 8'd1;
      regs.get_code     = 8'd2;
      regs.set_code     = 8'd3;
      regs.dot_ms       = 16'd500;
      regs.timeout_ms   = 16'd5000;
      regs.keepalive_ms = 16'd400;
      regs.sample_ms    = 16'd50;
      stored       = '0;
      confirmed    = 1'b0;
      keepalive_at = '0;
      sample_at    = '0;
      errors       = 0;
      checked      = 0;
      status_seen  = '0;
      drop_session();
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void drop_session();
      mode     = MODE_IDLE;
      level    = 1'b0;
      press_at = '0;
      symbols  = 0;
      entered  = '0;
    endfunction

    function void write_register(logic [2:0] addr, logic [15:0] data);
      case (cfg_reg_t'(addr))
        REG_CLASS:     regs.class_code   = data[7:0];
        REG_CHECK:     regs.check_code   = data[7:0];
        REG_GET:       regs.get_code     = data[7:0];
        REG_SET:       regs.set_code     = data[7:0];
        REG_DOT:       regs.dot_ms       = data;
        REG_TIMEOUT:   regs.timeout_ms   = data;
        REG_KEEPALIVE: regs.keepalive_ms = data;
        REG_SAMPLE:    regs.sample_ms    = data;
        default: ;
      endcase
    endfunction

    function void open_session(mode_t m, logic [31:0] now);
      mode         = m;
      confirmed    = 1'b0;
      press_at     = now;
      keepalive_at = now;
      sample_at    = now;
    endfunction

    function logic [3:0] close_session();
      logic [3:0] st;
      st = ST_NONE;
      case (mode)
        MODE_CHECK: begin
          if (stored[0] == SYM_NONE || entered == stored) confirmed = 1'b1;
        end
        MODE_GET: begin
          if (entered == stored) begin
            confirmed = 1'b1;
            st = ST_CONFIRM;
          end else begin
            confirmed = 1'b0;
            st = ST_VERIFY_FAILED;
          end
        end
        default: begin
          stored = entered;
          st = ST_OK;
        end
      endcase
      drop_session();
      return st;
    endfunction

    function void note_request(req_t w);
      rsp_t        want;
      logic [31:0] now;
      logic [31:0] held;
      want = '0;
      now  = w.now_ms;
      if (!w.req_type) begin
        // any request abandons the running session first
        drop_session();
        if (w.req_class != regs.class_code) begin
          want.status_code = ST_BAD_CLASS;
          want.reply_sent  = 1'b1;
        end else if (w.req_ins == regs.check_code) begin
          open_session(MODE_CHECK, now);
        end else if (w.req_ins == regs.get_code) begin
          if (stored[0] == SYM_NONE) begin
            want.status_code = ST_NOT_SATISFIED;
            want.reply_sent  = 1'b1;
          end else begin
            open_session(MODE_GET, now);
          end
        end else if (w.req_ins == regs.set_code) begin
          if (stored[0] != SYM_NONE && !confirmed) begin
            want.status_code = ST_VERIFY_FAILED;
            want.reply_sent  = 1'b1;
          end else begin
            open_session(MODE_SET, now);
          end
        end else begin
          want.status_code = ST_BAD_INS;
          want.reply_sent  = 1'b1;
        end
      end else if (mode != MODE_IDLE) begin
        if (now - press_at > {16'd0, regs.timeout_ms}) begin
          if (mode != MODE_CHECK) want.status_code = ST_TIMEOUT;
          want.reply_sent = 1'b1;
          drop_session();
        end else if (mode != MODE_CHECK && now - keepalive_at > {16'd0, regs.keepalive_ms}) begin
          // keepalive takes the word; the button is not looked at
          want.status_code = ST_KEEPALIVE;
          want.reply_sent  = 1'b1;
          keepalive_at     = now;
        end else if (now - sample_at > {16'd0, regs.sample_ms}) begin
          sample_at = now;
          if (w.button_level != level) begin
            level = w.button_level;
            if (level) begin
              press_at = now;
            end else begin
              held = now - press_at;
              if (symbols < PIN_LENGTH) begin
                entered[symbols] = (held < {16'd0, regs.dot_ms}) ? SYM_SHORT : SYM_LONG;
                symbols++;
              end
              if (symbols >= PIN_LENGTH || (mode == MODE_CHECK && stored[0] == SYM_NONE)) begin
                want.reply_sent  = 1'b1;
                want.status_code = close_session();
              end
            end
          end
        end
      end
      want.pin_confirmed = confirmed;
      want.session_busy  = (mode != MODE_IDLE);
      want.led_on        = (mode != MODE_IDLE) && level;
      due.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d field %s got %0d want %0d", checked, name, got, want));
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = due.pop_front();
        status_seen[want.status_code] = 1'b1;
        compare_field("status_code", got.status_code, want.status_code);
        compare_field("reply_sent", got.reply_sent, want.reply_sent);
        compare_field("pin_confirmed", got.pin_confirmed, want.pin_confirmed);
        compare_field("led_on", got.led_on, want.led_on);
        compare_field("session_busy", got.session_busy, want.session_busy);
        checked++;
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req_word;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  pin_session_tracker sb;
  cfg_t        cur;
  logic [31:0] clock_ms;
  logic [5:0]  pin_guess;
  bit          pin_known;
  bit          hold_done;
  int          items_sent;
  int          words_in;
  int          settings_used;
  int          steady_left;
  int          idle_cycles;

  press_duration_pin_entry i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (req_valid && !req_stall) begin
        sb.note_request(req_word);
        words_in <= words_in + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        sb.check_response(rsp_word);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_addr, cfg_wdata);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : receiver
    int n;
    int r;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && words_in >= 250) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        n = $urandom_range(1, 30);
        repeat (n) begin
          if (r < 45)      rsp_stall <= 1'b0;
          else if (r < 90) rsp_stall <= ($urandom_range(0, 99) < 30);
          else             rsp_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer(req_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic send_sample(logic lvl, logic [31:0] now);
    req_t w;
    w.req_type     = 1'b1;
    w.req_class    = 8'($urandom);
    w.req_ins      = 8'($urandom);
    w.button_level = lvl;
    w.now_ms       = now;
    offer(w);
  endtask

  task automatic send_req(logic [7:0] cls, logic [7:0] ins, logic [31:0] now);
    req_t w;
    w.req_type     = 1'b0;
    w.req_class    = cls;
    w.req_ins      = ins;
    w.button_level = 1'($urandom);
    w.now_ms       = now;
    offer(w);
  endtask

  // drop valid, wait for every result, then let the pipeline drain
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(cfg_reg_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // byte registers get junk in the upper half, which the block must drop
  task automatic apply_config(cfg_t c);
    put_register(REG_CLASS, {8'($urandom), c.class_code});
    put_register(REG_CHECK, {8'($urandom), c.check_code});
    put_register(REG_GET, {8'($urandom), c.get_code});
    put_register(REG_SET, {8'($urandom), c.set_code});
    put_register(REG_DOT, c.dot_ms);
    put_register(REG_TIMEOUT, c.timeout_ms);
    put_register(REG_KEEPALIVE, c.keepalive_ms);
    put_register(REG_SAMPLE, c.sample_ms);
    cfg_valid <= 1'b0;
    cur = c;
    settings_used++;
  endtask

  function automatic cfg_t make_cfg(logic [7:0] cls, logic [7:0] chk, logic [7:0] get,
                                    logic [7:0] set, logic [15:0] dot, logic [15:0] tmo,
                                    logic [15:0] kal, logic [15:0] smp);
    cfg_t c;
    c.class_code   = cls;
    c.check_code   = chk;
    c.get_code     = get;
    c.set_code     = set;
    c.dot_ms       = dot;
    c.timeout_ms   = tmo;
    c.keepalive_ms = kal;
    c.sample_ms    = smp;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.class_code   = 8'($urandom);
    c.check_code   = 8'($urandom);
    c.get_code     = ($urandom_range(0, 4) == 0) ? c.check_code : 8'($urandom);
    c.set_code     = ($urandom_range(0, 4) == 0) ? c.get_code : 8'($urandom);
    c.dot_ms       = 16'($urandom_range(20, 2000));
    c.sample_ms    = 16'($urandom_range(1, 100));
    c.keepalive_ms = 16'($urandom_range(50, 3000));
    c.timeout_ms   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 1000))
                                                 : 16'($urandom_range(2000, 65535));
    return c;
  endfunction

  // one session: a start word then up to six press/release pairs, each sample sent
  // twice so a keepalive that swallows the first does not lose the edge
  task automatic one_session();
    logic [31:0] s;
    logic [31:0] lo;
    logic [31:0] dot;
    logic [31:0] d;
    logic [7:0]  cls;
    logic [7:0]  ins;
    logic [5:0]  pattern;
    req_t        stray;
    int          op;
    int          r;
    s   = {16'd0, cur.sample_ms} + 32'd1;
    lo  = 2 * s;
    dot = {16'd0, cur.dot_ms};
    r   = $urandom_range(0, 99);
    op  = $urandom_range(0, 2);
    cls = cur.class_code;
    case (op)
      0:       ins = cur.check_code;
      1:       ins = cur.get_code;
      default: ins = cur.set_code;
    endcase
    if (r < 10) begin
      cls = 8'($urandom);
      ins = 8'($urandom);
    end else if (r < 15) begin
      ins = 8'($urandom);
    end
    pattern = (op != 2 && pin_known && $urandom_range(0, 3) != 0) ? pin_guess : 6'($urandom);
    if (op == 2 && r >= 15) begin
      pin_guess = pattern;
      pin_known = 1'b1;
    end
    clock_ms += s + $urandom_range(0, 3);
    send_req(cls, ins, clock_ms);
    for (int k = 0; k < PIN_LENGTH; k++) begin
      if ($urandom_range(0, 99) < 4) begin
        stray = req_t'({$urandom, $urandom});
        if ($urandom_range(0, 1)) stray.now_ms = clock_ms + $urandom_range(0, 2 * s);
        offer(stray);
      end
      if ($urandom_range(0, 99) < 3) break;
      if ($urandom_range(0, 99) < 2) clock_ms += {16'd0, cur.timeout_ms} + $urandom_range(1, 100);
      if (!pattern[k])
        d = (lo + s < dot) ? $urandom_range(lo, dot - 1 - s) : lo;
      else
        d = ((dot + s > lo) ? dot + s : lo) + $urandom_range(0, s);
      clock_ms += s;
      send_sample(1'b1, clock_ms);
      send_sample(1'b1, clock_ms + s);
      clock_ms += d;
      send_sample(1'b0, clock_ms);
      send_sample(1'b0, clock_ms + s);
      clock_ms += s;
    end
  endtask

  task automatic run_phase(cfg_t c, int n);
    int target;
    settle();
    apply_config(c);
    target = items_sent + n;
    while (items_sent < target) one_session();
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_word  <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    sb = new();
    cur = sb.regs;
    clock_ms = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset settings
    send_sample(1'b1, 32'h0000_0000);           // idle: ignored
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_req(8'hFF, 8'hFF, 32'd0);              // wrong class
    send_req(8'h00, 8'h00, 32'd0);              // unknown instruction
    send_req(8'h00, 8'h02, 32'd10);             // verify with no PIN stored
    send_req(8'h00, 8'h03, 32'd1000);           // set session opens
    send_sample(1'b1, 32'd1401);                // keepalive due, button ignored
    send_sample(1'b1, 32'd1402);                // press
    send_sample(1'b0, 32'd7402);                // timed out
    send_req(8'h00, 8'h01, 32'hFFFF_FFF0);      // check session across the wrap
    send_sample(1'b1, 32'h0000_0040);
    send_sample(1'b1, 32'h0000_0050);           // too soon after last sample
    send_sample(1'b0, 32'h0000_00A4);           // no PIN: first release confirms
    send_req(8'h00, 8'h01, 32'd20000);
    send_sample(1'b0, 32'd30000);               // check timeout replies with no status

    run_phase(make_cfg(8'h5A, 8'd10, 8'd20, 8'd30, 16'd300, 16'd4000, 16'd1000, 16'd20), 85);
    clock_ms = 32'hFFFF_F000;
    run_phase(make_cfg(8'h00, 8'hFF, 8'hFE, 8'hFD, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1), 85);
    run_phase(make_cfg(8'hFF, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 85);
    run_phase(make_cfg(8'h00, 8'd9, 8'd7, 8'd7, 16'd0, 16'd0, 16'd0, 16'd0), 60);
    run_phase(random_cfg(), 85);
    run_phase(random_cfg(), 85);
    run_phase(random_cfg(), 85);
    settle();

    $display("covered %0d words in, %0d results checked over %0d register settings",
             words_in, sb.checked, settings_used + 1);
    $display("status codes seen (bit per code, ok..bad_class high): %b", sb.status_seen);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[press_duration_pin_entry.f]
hdl/pde_pkg.sv
hdl/pde_cfg.sv
hdl/pde_engine.sv
hdl/press_duration_pin_entry.sv
dv/testbench.sv
